[hw/rtl/bvm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_pkg
// shared types and constants of the battery voltage monitor
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int unsigned RefMillivolts = 3300;
    localparam int unsigned OverloadLimit = 64;
    localparam int unsigned OvlStep       = OverloadLimit / 8;
    localparam int unsigned OvlHalf       = OverloadLimit / 2;
    localparam int unsigned OvlW          = $clog2(OverloadLimit + 1);

    localparam logic [9:0]  AdcFull   = 10'd1023;
    localparam logic [31:0] BigThresh = 32'd1000000;

    // reciprocals for 32-bit unsigned division by 1023 (shift 42) and 1000 (shift 38)
    localparam logic [64:0] Recip1023 = 65'h1_0040_1005;
    localparam logic [63:0] Recip1000 = 64'd274877907;

    typedef enum logic [1:0] {
        REG_R1     = 2'd0,
        REG_R2     = 2'd1,
        REG_WEIGHT = 2'd2,
        REG_WARN   = 2'd3
    } t_reg_idx;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,   // latch sample, update overload counter
        OP_GCD_INI = 4'd2,   // load gcd operands
        OP_GCD_STP = 4'd3,   // one gcd step
        OP_DIV_A   = 4'd4,   // start r1 / g
        OP_DIV_B   = 4'd5,   // start r2 / g
        OP_MUL_N   = 4'd6,   // n = (a+b)*adc
        OP_DIV_N   = 4'd7,   // n / 1023 and big flag
        OP_MUL_REF = 4'd8,   // n*ref, d
        OP_DIV_RAW = 4'd9,   // start n / d
        OP_MUL_KP  = 4'd10,  // products of filter
        OP_DIV_KP  = 4'd11,  // keep / 1000
        OP_DIV_AD  = 4'd12,  // add / 1000
        OP_FILT    = 4'd13   // update filter
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_busy;
        logic need_gcd;
        logic r2_zero;
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/bvm_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface bvm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/bvm_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_divider
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bvm_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [31:0]      o_quot
);
    logic [31:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] w_shift;

    always_comb begin
        w_shift = {r_rem[31:0], r_quot[31]};
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_rem  = '0;
            n_quot = i_num;
            n_cnt  = 6'd32;
        end else if (r_cnt != 6'd0) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem  = w_shift - {1'b0, r_den};
                n_quot = {r_quot[30:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_quot;
endmodule
`default_nettype wire

[hw/rtl/bvm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_datapath
// registers, gcd engine, multipliers and divider of the monitor
// ----------------------------------------------------------------------------
module bvm_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [9:0]    i_adc,
    input  wire bvm_pkg::t_cmd i_cmd,
    output bvm_pkg::t_sts      o_sts,
    output logic [31:0]        o_raw_mv,
    output logic [15:0]        o_filtered_mv,
    output logic               o_overload,
    output logic               o_low_warning
);
    import bvm_pkg::*;

    logic [31:0] r_r1, r_r2, r_gcd, r_filt;
    logic [9:0]  r_weight;
    logic [15:0] r_warn;
    logic        r_gvalid;
    logic [OvlW-1:0] r_ovl;
    logic [9:0]  r_adc;
    logic [31:0] r_ga, r_gb;
    logic [4:0]  r_twos;
    logic        r_gdone;
    logic [31:0] r_a, r_b, r_n, r_d, r_keep, r_mk, r_ma;
    logic [31:0] r_nq, r_add;
    logic        r_big;
    logic [31:0] r_raw;

    logic        w_dstart;
    logic [31:0] w_dnum, w_dden, w_quot;
    logic        w_dbusy;
    logic [9:0]  w_w;
    logic [64:0] w_p1023;
    logic [31:0] w_ksrc;
    logic [63:0] w_p1000;

    bvm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_busy  (w_dbusy),
        .o_quot  (w_quot)
    );

    assign w_w = (i_cfg_data[9:0] == 10'd0 || i_cfg_data[9:0] > 10'd1000) ?
                 10'd1000 : i_cfg_data[9:0];

    assign w_p1023 = {33'd0, r_n} * Recip1023;
    assign w_ksrc  = (i_cmd.op == OP_DIV_AD) ? r_ma : r_mk;
    assign w_p1000 = {32'd0, w_ksrc} * Recip1000;

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = '0;
        unique case (i_cmd.op)
            OP_DIV_A:   begin w_dstart = 1'b1; w_dnum = r_r1; w_dden = r_gcd; end
            OP_DIV_B:   begin w_dstart = 1'b1; w_dnum = r_r2; w_dden = r_gcd; end
            OP_DIV_RAW: begin w_dstart = 1'b1; w_dnum = r_n; w_dden = r_d; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1     <= '0;
            r_r2     <= '0;
            r_weight <= 10'd1000;
            r_warn   <= '0;
            r_gcd    <= '0;
            r_gvalid <= 1'b0;
            r_filt   <= '0;
            r_ovl    <= '0;
            r_gdone  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_R1:     begin r_r1 <= i_cfg_data; r_gvalid <= 1'b0; end
                    REG_R2:     begin r_r2 <= i_cfg_data; r_gvalid <= 1'b0; end
                    REG_WEIGHT: r_weight <= w_w;
                    REG_WARN:   r_warn <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_adc <= i_adc;
                    if (i_adc == AdcFull) begin
                        if (r_ovl < OvlW'(OverloadLimit)) r_ovl <= r_ovl + OvlW'(1);
                    end else if (r_ovl > OvlW'(OvlStep)) begin
                        r_ovl <= r_ovl - OvlW'(OvlStep);
                    end else begin
                        r_ovl <= '0;
                    end
                end
                OP_GCD_INI: begin
                    r_ga    <= r_r1;
                    r_gb    <= r_r2;
                    r_twos  <= '0;
                    r_gdone <= 1'b0;
                    if (r_r1 == 32'd0) begin
                        r_gcd <= r_r2; r_gvalid <= 1'b1; r_gdone <= 1'b1;
                    end
                end
                OP_GCD_STP: begin
                    if (((r_ga | r_gb) & 32'd1) == 32'd0) begin
                        r_ga   <= r_ga >> 1;
                        r_gb   <= r_gb >> 1;
                        r_twos <= r_twos + 5'd1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= r_gb;
                        r_gb <= r_ga - r_gb;
                    end else if (r_gb == r_ga) begin
                        r_gcd    <= r_ga << r_twos;
                        r_gvalid <= 1'b1;
                        r_gdone  <= 1'b1;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                OP_DIV_B: r_a <= w_quot;
                OP_MUL_N: begin
                    r_b   <= w_quot;
                    r_n   <= 32'((r_a + w_quot) * {22'd0, r_adc});
                end
                OP_DIV_N: begin
                    r_big <= (r_n >= BigThresh);
                    r_nq  <= {9'd0, w_p1023[64:42]};
                end
                OP_MUL_REF: begin
                    r_n <= 32'((r_big ? r_nq : r_n) * 32'(RefMillivolts));
                    r_d <= r_big ? r_b : 32'(r_b * 32'd1023);
                end
                OP_MUL_KP: begin
                    r_raw <= (r_r2 == 32'd0 || r_gcd == 32'd0 || r_d == 32'd0) ?
                             32'd0 : w_quot;
                    r_mk  <= 32'(r_filt * (32'd1000 - {22'd0, r_weight}));
                    r_ma  <= 32'(((r_r2 == 32'd0 || r_gcd == 32'd0 || r_d == 32'd0) ?
                             32'd0 : w_quot) * {22'd0, r_weight});
                end
                OP_DIV_KP: r_keep <= {6'd0, w_p1000[63:38]};
                OP_DIV_AD: r_add  <= {6'd0, w_p1000[63:38]};
                OP_FILT: begin
                    r_filt <= (r_filt == 32'd0) ? r_raw : 32'(r_keep + r_add);
                end
                default: ;
            endcase
        end
    end

    assign o_sts.gcd_done = r_gdone;
    assign o_sts.div_busy = w_dbusy;
    assign o_sts.need_gcd = !r_gvalid;
    assign o_sts.r2_zero  = (r_r2 == 32'd0);

    assign o_raw_mv      = r_raw;
    assign o_filtered_mv = r_filt[15:0];
    assign o_overload    = (r_ovl >= OvlW'(OvlHalf)) && (r_r2 != 32'd0);
    assign o_low_warning = (r_filt[15:0] < r_warn);
endmodule
`default_nettype wire

[hw/rtl/bvm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_ctrl
// sequencer issuing datapath operations for one word
// ----------------------------------------------------------------------------
module bvm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire bvm_pkg::t_sts i_sts,
    output bvm_pkg::t_cmd      o_cmd
);
    import bvm_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_GINI  = 15'b000000000000010,
        S_GSTP  = 15'b000000000000100,
        S_DA    = 15'b000000000001000,
        S_DB    = 15'b000000000010000,
        S_MN    = 15'b000000000100000,
        S_DN    = 15'b000000001000000,
        S_MR    = 15'b000000010000000,
        S_DR    = 15'b000000100000000,
        S_MK    = 15'b000001000000000,
        S_DK    = 15'b000010000000000,
        S_DAD   = 15'b000100000000000,
        S_FILT  = 15'b001000000000000,
        S_OUT   = 15'b010000000000000,
        S_WAITD = 15'b100000000000000
    } t_state;

    t_state r_state, n_state, r_after, n_after;

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        o_cmd.op  = OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = OP_LOAD;
                n_state  = S_GINI;
            end
            S_GINI: begin
                if (i_sts.r2_zero) begin
                    n_state = S_MK;
                end else if (i_sts.need_gcd) begin
                    o_cmd.op = OP_GCD_INI;
                    n_state  = S_GSTP;
                end else begin
                    n_state = S_DA;
                end
            end
            S_GSTP: begin
                if (i_sts.gcd_done) begin
                    n_state = S_DA;
                end else begin
                    o_cmd.op = OP_GCD_STP;
                end
            end
            S_DA:  begin o_cmd.op = OP_DIV_A; n_state = S_WAITD; n_after = S_DB; end
            S_DB:  begin o_cmd.op = OP_DIV_B; n_state = S_WAITD; n_after = S_MN; end
            S_MN:  begin o_cmd.op = OP_MUL_N; n_state = S_DN; end
            S_DN:  begin o_cmd.op = OP_DIV_N; n_state = S_MR; end
            S_MR:  begin o_cmd.op = OP_MUL_REF; n_state = S_DR; end
            S_DR:  begin o_cmd.op = OP_DIV_RAW; n_state = S_WAITD; n_after = S_MK; end
            S_MK:  begin o_cmd.op = OP_MUL_KP; n_state = S_DK; end
            S_DK:  begin o_cmd.op = OP_DIV_KP; n_state = S_DAD; end
            S_DAD: begin o_cmd.op = OP_DIV_AD; n_state = S_FILT; end
            S_FILT: begin o_cmd.op = OP_FILT; n_state = S_OUT; end
            S_OUT: if (i_out_ready) begin
                n_state = S_IDLE;
            end
            S_WAITD: begin
                if (!i_sts.div_busy) n_state = r_after;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

[hw/rtl/battery_voltage_monitor_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_monitor_top
// adc sample to filtered battery millivolts with overload and low warning
// ----------------------------------------------------------------------------
// One word is handled at a time, from its acceptance to its result; the divider
// gcd is refreshed first when it is not valid (after reset or a resistor write).
// The work of a word centres on the shared one-bit-per-cycle 32-bit divider,
// used three times per word. A zero lower resistor skips the conversion.
// A stalled result holds off the next input word.
module battery_voltage_monitor_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    bvm_stream_if.sink   in_if,
    bvm_stream_if.source out_if
);
    import bvm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic [31:0] w_raw;
    logic [15:0] w_filt;
    logic w_ovl, w_low;

    bvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .o_in_ready  (in_if.ready),
        .o_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bvm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_adc         (in_if.data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_raw_mv      (w_raw),
        .o_filtered_mv (w_filt),
        .o_overload    (w_ovl),
        .o_low_warning (w_low)
    );

    assign out_if.data = {w_raw, w_filt, w_ovl, w_low};
endmodule
`default_nettype wire
